@@ hw/rtl/adsr_envelope_voice_bank_core_macros.svh @@
// ----------------------------------------------------------------------------
// ADSR voice bank assertion macros
// Concurrent assertion wrappers. They compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ADSR_ENVELOPE_VOICE_BANK_CORE_MACROS_SVH
`define ADSR_ENVELOPE_VOICE_BANK_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define ADSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define ADSR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ADSR_ASSERT(lbl, prop, msg)
`define ADSR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hw/rtl/adsr_pkg.sv @@
// ----------------------------------------------------------------------------
// ADSR voice bank package
// Shared widths, item types, sequencer states and helper functions.
// ----------------------------------------------------------------------------
package adsr_pkg;

  localparam int NUM_VOICES = 16;
  localparam int SLOT_BITS  = 4;
  localparam int TIME_BITS  = 20;
  localparam int AGE_BITS   = TIME_BITS + 4;
  localparam int DT_BITS    = 16;
  localparam int LVL_BITS   = 16;
  localparam int NUM_BITS   = TIME_BITS + LVL_BITS;
  localparam int DIV_CNT_BITS = $clog2(LVL_BITS) + 1;

  localparam logic [LVL_BITS-1:0]  LEVEL_ONE = LVL_BITS'(32768);
  localparam logic [AGE_BITS-1:0]  AGE_MAX   = {AGE_BITS{1'b1}};
  localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(NUM_VOICES - 1);

  typedef enum logic [1:0] {
    START_TICK = 2'd0,
    START_OK   = 2'd1,
    START_FULL = 2'd2
  } start_status_t;

  typedef struct packed {
    logic                 action;
    logic [DT_BITS-1:0]   delta_time;
    logic [TIME_BITS-1:0] attack_time;
    logic [TIME_BITS-1:0] decay_time;
    logic [TIME_BITS-1:0] hold_time;
    logic [TIME_BITS-1:0] release_time;
    logic [LVL_BITS-1:0]  peak_level;
    logic [LVL_BITS-1:0]  sustain_level;
  } in_item_t;

  typedef struct packed {
    logic [SLOT_BITS-1:0] slot_index;
    logic                 slot_active;
    logic [LVL_BITS-1:0]  level;
    logic                 voice_ended;
    start_status_t        start_status;
    logic                 is_last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_AGE,
    ST_SUM_H,
    ST_SUM_R,
    ST_CLASS,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_DIV_WAIT,
    ST_EMIT
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Levels above one are saturated to one when a voice starts.
  function automatic logic [LVL_BITS-1:0] clamp_level(input logic [LVL_BITS-1:0] v);
    return (v > LEVEL_ONE) ? LEVEL_ONE : v;
  endfunction

endpackage

@@ hw/rtl/adsr_div.sv @@
// ----------------------------------------------------------------------------
// ADSR level divider
// Restoring divider, one quotient bit per cycle, for quotients below 2^16.
// ----------------------------------------------------------------------------
module adsr_div
  import adsr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_BITS-1:0]  num,
  input  logic [TIME_BITS-1:0] den,
  output div_stat_t            stat,
  output logic [LVL_BITS-1:0]  quot
);

  logic [TIME_BITS-1:0]    rem_r, rem_nxt;
  logic [LVL_BITS-1:0]     low_r, low_nxt;
  logic [TIME_BITS-1:0]    den_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;
  logic                    busy_r, done_r;
  logic [TIME_BITS:0]      shifted;
  logic [TIME_BITS:0]      diff;
  logic                    ge;

  // The caller guarantees num < den * 2^16, so the top bits start below den.
  always_comb begin
    shifted = {rem_r, low_r[LVL_BITS-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = (shifted >= {1'b0, den_r});
    rem_nxt = ge ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
    low_nxt = {low_r[LVL_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_BITS'(LVL_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[NUM_BITS-1:LVL_BITS];
      low_r <= num[LVL_BITS-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = low_r;

endmodule

@@ hw/rtl/adsr_envelope_voice_bank_core.sv @@
// ----------------------------------------------------------------------------
// ADSR envelope voice bank core
// Sixteen voice slots with piecewise-linear attack, decay, hold and release.
// ----------------------------------------------------------------------------
// The bank takes one item at a time and is not ready until every result of
// that item has been computed. A start item walks the slots from slot 0, one
// slot per cycle, and takes the first free one, giving one result (start
// accepted, or bank full with slot 0). A tick item walks all 16 slots; a
// free slot gives no result, a busy slot gives one result, in rising slot
// order, with is_last on the final one. A busy slot goes through the add
// chain for the phase boundaries, two passes through the shared 16 x 20
// multiplier and the shared restoring divider. Slots in their hold phase or
// just ended skip the multiplier and the divider.
// Results wait in an output register, so a stalled result channel only
// holds the sequencer when the next result is ready to go.
// ----------------------------------------------------------------------------
`include "adsr_envelope_voice_bank_core_macros.svh"

module adsr_envelope_voice_bank_core
  import adsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Per-slot envelope storage. Each array is read only at the slot that the
  // sequencer currently visits.
  logic [AGE_BITS-1:0]  age_mem [NUM_VOICES];
  logic [TIME_BITS-1:0] atk_mem [NUM_VOICES];
  logic [TIME_BITS-1:0] dec_mem [NUM_VOICES];
  logic [TIME_BITS-1:0] hld_mem [NUM_VOICES];
  logic [TIME_BITS-1:0] rel_mem [NUM_VOICES];
  logic [LVL_BITS-1:0]  pk_mem  [NUM_VOICES];
  logic [LVL_BITS-1:0]  sus_mem [NUM_VOICES];

  seq_state_t            state_r, state_nxt;
  logic [SLOT_BITS-1:0]  slot_r, slot_nxt;
  logic [NUM_VOICES-1:0] busy_r, busy_nxt;
  in_item_t              in_r, in_nxt;
  logic [AGE_BITS-1:0]   age_r, age_nxt;
  logic [AGE_BITS-1:0]   end_d_r, end_d_nxt;
  logic [AGE_BITS-1:0]   end_h_r, end_h_nxt;
  logic [AGE_BITS-1:0]   end_r_r, end_r_nxt;
  logic [LVL_BITS-1:0]   a1_r, a1_nxt, a2_r, a2_nxt;
  logic [TIME_BITS-1:0]  x1_r, x1_nxt, x2_r, x2_nxt;
  logic [TIME_BITS-1:0]  den_r, den_nxt;
  logic [NUM_BITS-1:0]   acc_r, acc_nxt;
  out_item_t             res_r, res_nxt;
  out_item_t             out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  logic                  start_we;
  logic                  age_we;
  logic                  div_start;
  div_stat_t             div_stat;
  logic [LVL_BITS-1:0]   div_quot;

  logic [NUM_VOICES-1:0] hi_mask;
  logic                  hi_busy;
  logic [AGE_BITS:0]     age_sum;
  logic [AGE_BITS-1:0]   atk_ext, dec_ext, hld_ext, rel_ext;
  logic [AGE_BITS-1:0]   since_atk;
  logic [AGE_BITS-1:0]   to_end;
  logic [LVL_BITS-1:0]   mul_a;
  logic [TIME_BITS-1:0]  mul_x;
  logic [NUM_BITS-1:0]   mul_p;

  // The shared multiplier: first pass forms a1 * x1, second adds a2 * x2.
  assign mul_a = (state_r == ST_MUL1) ? a1_r : a2_r;
  assign mul_x = (state_r == ST_MUL1) ? x1_r : x2_r;
  assign mul_p = NUM_BITS'(mul_a) * NUM_BITS'(mul_x);

  assign atk_ext = AGE_BITS'(atk_mem[slot_r]);
  assign dec_ext = AGE_BITS'(dec_mem[slot_r]);
  assign hld_ext = AGE_BITS'(hld_mem[slot_r]);
  assign rel_ext = AGE_BITS'(rel_mem[slot_r]);
  assign since_atk = age_r - atk_ext;
  assign to_end    = end_r_r - age_r;
  assign age_sum   = {1'b0, age_mem[slot_r]} + (AGE_BITS + 1)'(in_r.delta_time);

  // A tick result is the final one when no slot above the current one is busy.
  always_comb begin
    for (int i = 0; i < NUM_VOICES; i++) begin
      hi_mask[i] = (SLOT_BITS'(i) > slot_r);
    end
    hi_busy = |(busy_r & hi_mask);
  end

  adsr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_r),
    .den   (den_r),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    busy_nxt      = busy_r;
    in_nxt        = in_r;
    age_nxt       = age_r;
    end_d_nxt     = end_d_r;
    end_h_nxt     = end_h_r;
    end_r_nxt     = end_r_r;
    a1_nxt        = a1_r;
    a2_nxt        = a2_r;
    x1_nxt        = x1_r;
    x2_nxt        = x2_r;
    den_nxt       = den_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    start_we      = 1'b0;
    age_we        = 1'b0;
    div_start     = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          slot_nxt  = '0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (in_r.action) begin
          // Start: claim the lowest free slot, or report a full bank.
          if (!busy_r[slot_r]) begin
            start_we               = 1'b1;
            busy_nxt[slot_r]       = 1'b1;
            res_nxt.slot_index     = slot_r;
            res_nxt.slot_active    = 1'b1;
            res_nxt.level          = '0;
            res_nxt.voice_ended    = 1'b0;
            res_nxt.start_status   = START_OK;
            res_nxt.is_last        = 1'b1;
            state_nxt              = ST_EMIT;
          end else if (slot_r == SLOT_LAST) begin
            res_nxt.slot_index     = '0;
            res_nxt.slot_active    = 1'b0;
            res_nxt.level          = '0;
            res_nxt.voice_ended    = 1'b0;
            res_nxt.start_status   = START_FULL;
            res_nxt.is_last        = 1'b1;
            state_nxt              = ST_EMIT;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
        end else begin
          if (busy_r[slot_r]) begin
            state_nxt = ST_AGE;
          end else if (slot_r == SLOT_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
        end
      end

      ST_AGE: begin
        // Saturating age update, and the end of the decay phase.
        age_nxt   = (age_sum >= (AGE_BITS + 1)'(AGE_MAX)) ? AGE_MAX
                                                          : age_sum[AGE_BITS-1:0];
        age_we    = 1'b1;
        end_d_nxt = atk_ext + dec_ext;
        state_nxt = ST_SUM_H;
      end

      ST_SUM_H: begin
        end_h_nxt = end_d_r + hld_ext;
        state_nxt = ST_SUM_R;
      end

      ST_SUM_R: begin
        end_r_nxt = end_h_r + rel_ext;
        state_nxt = ST_CLASS;
      end

      ST_CLASS: begin
        res_nxt.slot_index   = slot_r;
        res_nxt.slot_active  = 1'b1;
        res_nxt.level        = '0;
        res_nxt.voice_ended  = 1'b0;
        res_nxt.start_status = START_TICK;
        res_nxt.is_last      = !hi_busy;
        a2_nxt  = '0;
        x2_nxt  = '0;
        if (age_r < atk_ext) begin
          // Attack ramp: peak * age / attack.
          a1_nxt    = pk_mem[slot_r];
          x1_nxt    = age_r[TIME_BITS-1:0];
          den_nxt   = atk_mem[slot_r];
          state_nxt = ST_MUL1;
        end else if (age_r < end_d_r) begin
          // Decay line from peak down (or up) to the sustain level.
          a1_nxt    = pk_mem[slot_r];
          x1_nxt    = dec_mem[slot_r] - since_atk[TIME_BITS-1:0];
          a2_nxt    = sus_mem[slot_r];
          x2_nxt    = since_atk[TIME_BITS-1:0];
          den_nxt   = dec_mem[slot_r];
          state_nxt = ST_MUL1;
        end else if (age_r < end_h_r) begin
          res_nxt.level = sus_mem[slot_r];
          state_nxt     = ST_EMIT;
        end else if (age_r < end_r_r) begin
          // Release: sustain * remaining / release.
          a1_nxt    = sus_mem[slot_r];
          x1_nxt    = to_end[TIME_BITS-1:0];
          den_nxt   = rel_mem[slot_r];
          state_nxt = ST_MUL1;
        end else begin
          // Release is over: the voice ends and its slot is freed.
          busy_nxt[slot_r]    = 1'b0;
          res_nxt.slot_active = 1'b0;
          res_nxt.voice_ended = 1'b1;
          state_nxt           = ST_EMIT;
        end
      end

      ST_MUL1: begin
        acc_nxt   = mul_p;
        state_nxt = ST_MUL2;
      end

      ST_MUL2: begin
        acc_nxt   = acc_r + mul_p;
        state_nxt = ST_DIV;
      end

      ST_DIV: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end

      ST_DIV_WAIT: begin
        if (div_stat.done) begin
          res_nxt.level = div_quot;
          state_nxt     = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          if (in_r.action || slot_r == SLOT_LAST) begin
            state_nxt = ST_IDLE;
          end else begin
            slot_nxt  = slot_r + 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      busy_r      <= '0;
      out_valid_r <= 1'b0;
      slot_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      slot_r      <= slot_nxt;
    end
  end

  // Working registers of the sequencer; no reset needed.
  always_ff @(posedge clk) begin
    in_r    <= in_nxt;
    age_r   <= age_nxt;
    end_d_r <= end_d_nxt;
    end_h_r <= end_h_nxt;
    end_r_r <= end_r_nxt;
    a1_r    <= a1_nxt;
    a2_r    <= a2_nxt;
    x1_r    <= x1_nxt;
    x2_r    <= x2_nxt;
    den_r   <= den_nxt;
    acc_r   <= acc_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

  // Slot storage writes: a start loads the envelope and clears the age,
  // a tick writes back the updated age.
  always_ff @(posedge clk) begin
    if (start_we) begin
      age_mem[slot_r] <= '0;
      atk_mem[slot_r] <= in_r.attack_time;
      dec_mem[slot_r] <= in_r.decay_time;
      hld_mem[slot_r] <= in_r.hold_time;
      rel_mem[slot_r] <= in_r.release_time;
      pk_mem[slot_r]  <= clamp_level(in_r.peak_level);
      sus_mem[slot_r] <= clamp_level(in_r.sustain_level);
    end else if (age_we) begin
      age_mem[slot_r] <= age_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ADSR_ASSERT_ALWAYS(a_reset_no_out, !rst_n |=> !out_valid, "result valid right after reset")
  `ADSR_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "second item taken while busy")
  `ADSR_ASSERT(a_div_free, div_start |-> !div_stat.busy, "divider restarted while busy")
  `ADSR_ASSERT(a_div_range, div_stat.done |-> div_quot <= LEVEL_ONE, "level above one")
  `ADSR_ASSERT(a_ended_silent, out_valid && out_data.voice_ended |-> out_data.level == '0 && !out_data.slot_active, "ended voice not silent")

endmodule
